@@ hw/rtl/apt_pkg.sv @@
// Package for the affine point transform unit: widths, opcodes and the
// struct types passed between the pipeline modules. No dependencies.
package apt_pkg;

	localparam int ELEM_W          = 32;
	localparam int PROD_W          = 2 * ELEM_W;
	localparam int NROW            = 4;
	localparam int NCOL            = 4;
	localparam int NCOMP           = 3;
	localparam int SEL_W           = $clog2(NROW);
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_POINT = 1'b1
	} op_t;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Rows 0..3 of matrix columns 0..2; column 3 never feeds a result.
	typedef elem_t [NROW-1:0][NCOMP-1:0] mat_cols_t;
	typedef elem_t [NCOMP-1:0] vec_t;

	typedef struct packed {
		prod_t [NCOMP-1:0][NCOMP-1:0] prod;
		vec_t                         trans;
	} prod_set_t;

	typedef struct packed {
		vec_t coord;
		logic sat;
	} res_t;

endpackage

@@ hw/rtl/apt_in_if.sv @@
// Input channel of the affine point transform unit: one beat is either a
// matrix element write or a point. Depends on apt_pkg.
interface apt_in_if import apt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic        [SEL_W-1:0]  row_sel;
	logic        [SEL_W-1:0]  col_sel;
	logic signed [ELEM_W-1:0] elem_value;
	logic signed [ELEM_W-1:0] point_x;
	logic signed [ELEM_W-1:0] point_y;
	logic signed [ELEM_W-1:0] point_z;

	modport source (
		output valid, opcode, row_sel, col_sel, elem_value, point_x, point_y, point_z,
		input  ready
	);
	modport sink (
		input  valid, opcode, row_sel, col_sel, elem_value, point_x, point_y, point_z,
		output ready
	);
endinterface

@@ hw/rtl/apt_out_if.sv @@
// Result channel of the affine point transform unit: one beat per point.
// Depends on apt_pkg.
interface apt_out_if import apt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] out_x;
	logic signed [ELEM_W-1:0] out_y;
	logic signed [ELEM_W-1:0] out_z;
	logic                     sat_flag;

	modport source (
		output valid, out_x, out_y, out_z, sat_flag,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, sat_flag,
		output ready
	);
endinterface

@@ hw/rtl/apt_matrix_store.sv @@
// Transform matrix register file, reset to identity, one element written
// per write beat. Depends on apt_pkg.
module apt_matrix_store import apt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [SEL_W-1:0] wr_row,
	input  logic [SEL_W-1:0] wr_col,
	input  elem_t            wr_data,
	output mat_cols_t        cols
);

	logic [ELEM_W-1:0] mat_q [NROW][NCOL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NROW; r++) begin
				for (int c = 0; c < NCOL; c++) begin
					mat_q[r][c] <= (r == c) ? (ELEM_W'(1) << FRAC_BITS) : '0;
				end
			end
		end else if (we) begin
			mat_q[wr_row][wr_col] <= wr_data;
		end
	end

	always_comb begin
		for (int r = 0; r < NROW; r++) begin
			for (int c = 0; c < NCOMP; c++) begin
				cols[r][c] = mat_q[r][c];
			end
		end
	end

endmodule

@@ hw/rtl/apt_mul_array.sv @@
// Nine parallel 32x32 signed multipliers with their result register, plus
// the translation row carried alongside. Depends on apt_pkg.
module apt_mul_array import apt_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  mat_cols_t mat_s1,
	input  vec_t      point_s1,
	output prod_set_t prod_s2
);

	prod_set_t prod_d;

	always_comb begin
		for (int k = 0; k < NCOMP; k++) begin
			for (int i = 0; i < NCOMP; i++) begin
				prod_d.prod[k][i] = PROD_W'($signed(mat_s1[k][i]) * $signed(point_s1[k]));
			end
		end
		for (int i = 0; i < NCOMP; i++) begin
			prod_d.trans[i] = mat_s1[NROW-1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

@@ hw/rtl/apt_sum_sat.sv @@
// Sums the products of each output component, shifts out the fraction with
// floor rounding, adds the translation and saturates. Depends on apt_pkg.
module apt_sum_sat import apt_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  prod_set_t prod_s2,
	output res_t      res
);

	localparam int SUM_W = PROD_W + 2;
	localparam int SH_W  = SUM_W - FRAC_BITS;
	localparam int R_W   = SH_W + 1;
	localparam int SAT_W = (COORD_WIDTH > ELEM_W) ? ELEM_W : COORD_WIDTH;
	localparam logic signed [R_W-1:0] SMAX = R_W'((64'd1 << (SAT_W - 1)) - 64'd1);
	localparam logic signed [R_W-1:0] SMIN = ~SMAX;

	logic signed [SUM_W-1:0] sum   [NCOMP];
	logic signed [SH_W-1:0]  sh    [NCOMP];
	logic signed [R_W-1:0]   r     [NCOMP];
	logic                    hi_ov [NCOMP];
	logic                    lo_ov [NCOMP];

	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			sum[i] = SUM_W'($signed(prod_s2.prod[0][i]))
			       + SUM_W'($signed(prod_s2.prod[1][i]))
			       + SUM_W'($signed(prod_s2.prod[2][i]));
			sh[i]  = sum[i][SUM_W-1:FRAC_BITS];
			r[i]   = R_W'(sh[i]) + R_W'($signed(prod_s2.trans[i]));
			hi_ov[i] = r[i] > SMAX;
			lo_ov[i] = r[i] < SMIN;
			if (hi_ov[i]) begin
				res.coord[i] = SMAX[ELEM_W-1:0];
			end else if (lo_ov[i]) begin
				res.coord[i] = SMIN[ELEM_W-1:0];
			end else begin
				res.coord[i] = r[i][ELEM_W-1:0];
			end
		end
		res.sat = hi_ov[0] | lo_ov[0] | hi_ov[1] | lo_ov[1] | hi_ov[2] | lo_ov[2];
	end

endmodule

@@ hw/rtl/affine_point_transform_unit.sv @@
// Top level of the affine point transform unit: matrix store, input stage,
// multiplier stage and saturating result register. Depends on apt_pkg,
// apt_in_if, apt_out_if, apt_matrix_store, apt_mul_array and apt_sum_sat.
//
//   port      dir   beat
//   items     in    matrix element write or point x,y,z
//   results   out   out_x,y,z and sat_flag, one per point beat
//
// The nine multipliers set the stage split: a point beat passes the input,
// multiplier and result registers; points enter every cycle unless stalled.
// A write beat updates the matrix at acceptance and gives no result beat.
// Reset loads the identity matrix and empties the pipeline.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up behind a stalled result.
module affine_point_transform_unit import apt_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	apt_in_if.sink   items,
	apt_out_if.source results
);

	logic      v1_s1;
	logic      v2_s2;
	logic      v3_q;
	logic      adv3;
	logic      adv2;
	logic      in_acc;
	logic      mat_we;
	mat_cols_t cols;
	mat_cols_t mat_s1;
	vec_t      point_s1;
	prod_set_t prod_s2;
	res_t      res;
	res_t      res_q;

	assign adv3        = !v3_q || results.ready;
	assign adv2        = !v2_s2 || adv3;
	assign items.ready = !v1_s1 || adv2;
	assign in_acc      = items.valid && items.ready;
	assign mat_we      = in_acc && (items.opcode == OP_WRITE);

	apt_matrix_store #(
		.FRAC_BITS (FRAC_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mat_we),
		.wr_row  (items.row_sel),
		.wr_col  (items.col_sel),
		.wr_data (items.elem_value),
		.cols    (cols)
	);

	always_ff @(posedge clk) begin
		if (items.ready) begin
			mat_s1      <= cols;
			point_s1[0] <= items.point_x;
			point_s1[1] <= items.point_y;
			point_s1[2] <= items.point_z;
		end
	end

	apt_mul_array u_mul (
		.clk      (clk),
		.en       (adv2),
		.mat_s1   (mat_s1),
		.point_s1 (point_s1),
		.prod_s2  (prod_s2)
	);

	apt_sum_sat #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_sum (
		.prod_s2 (prod_s2),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (adv3) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			if (items.ready) begin
				v1_s1 <= in_acc && (items.opcode == OP_POINT);
			end
			if (adv2) begin
				v2_s2 <= v1_s1;
			end
			if (adv3) begin
				v3_q <= v2_s2;
			end
		end
	end

	assign results.valid    = v3_q;
	assign results.out_x    = res_q.coord[0];
	assign results.out_y    = res_q.coord[1];
	assign results.out_z    = res_q.coord[2];
	assign results.sat_flag = res_q.sat;

`ifndef SYNTH
	localparam int SAT_W = (COORD_WIDTH > ELEM_W) ? ELEM_W : COORD_WIDTH;
	localparam logic signed [ELEM_W-1:0] OMAX = ELEM_W'((64'd1 << (SAT_W - 1)) - 64'd1);
	localparam logic signed [ELEM_W-1:0] OMIN = -OMAX - ELEM_W'(1);

	a_write_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && items.opcode == OP_WRITE) |=> !v1_s1)
		else $error("write beat occupied a pipeline slot");

	a_point_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && items.opcode == OP_POINT) |=> v1_s1)
		else $error("accepted point beat lost at the input stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> (v1_s1 && v2_s2 && v3_q && !results.ready))
		else $error("input stalled while the pipeline had room");

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.sat_flag) |->
			(results.out_x == OMAX || results.out_x == OMIN ||
			 results.out_y == OMAX || results.out_y == OMIN ||
			 results.out_z == OMAX || results.out_z == OMIN))
		else $error("saturation flagged with no component at a bound");
`endif

endmodule

@@ verif/testbench.sv @@
// Testbench for affine_point_transform_unit: a directed table of matrix writes and
// points, then random beats under changing idle patterns, checked against a predictor.
// Depends on apt_pkg, apt_in_if, apt_out_if and the RTL top level.
module testbench;
	import apt_pkg::*;

	localparam int FRAC            = FRAC_BITS_DEF;
	localparam int COORD_W         = COORD_WIDTH_DEF;
	localparam int SAT_W           = (COORD_W > ELEM_W) ? ELEM_W : COORD_W;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int NPHASE          = 4;
	localparam int DRAIN           = 20;
	localparam int LIMIT           = 100000;

	localparam logic signed [127:0] SAT_MAX = (128'sd1 <<< (SAT_W - 1)) - 128'sd1;
	localparam logic signed [127:0] SAT_MIN = -SAT_MAX - 128'sd1;
	localparam logic [ELEM_W-1:0]   ONE     = 32'h0001_0000;
	localparam logic [ELEM_W-1:0]   NEG_ONE = 32'hFFFF_0000;
	localparam logic [ELEM_W-1:0]   EMAX    = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0]   EMIN    = 32'h8000_0000;

	typedef struct packed {
		logic [ELEM_W-1:0] x;
		logic [ELEM_W-1:0] y;
		logic [ELEM_W-1:0] z;
		logic              sat;
	} point_beat_t;

	typedef struct packed {
		op_t               op;
		logic [SEL_W-1:0]  row;
		logic [SEL_W-1:0]  col;
		logic [ELEM_W-1:0] elem;
		logic [ELEM_W-1:0] px;
		logic [ELEM_W-1:0] py;
		logic [ELEM_W-1:0] pz;
		logic              typed;
		point_beat_t       want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	apt_in_if  item_bus ();
	apt_out_if result_bus ();

	affine_point_transform_unit #(
		.FRAC_BITS  (FRAC),
		.COORD_WIDTH(COORD_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_bus),
		.results(result_bus)
	);

	logic [ELEM_W-1:0] matrix_copy [NROW][NCOL];
	point_beat_t       pending_points [$];
	point_beat_t       front_point;
	stim_t             dir_rows [$];
	int                error_count = 0;
	int                cycle_count = 0;
	int                gap_pct = 0;
	int                stall_pct = 0;

	always #6 clk = ~clk;

	task automatic flag_error(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic void reset_matrix();
		for (int r = 0; r < NROW; r++)
			for (int c = 0; c < NCOL; c++)
				matrix_copy[r][c] = (r == c) ? ONE : '0;
	endfunction

	function automatic point_beat_t transform_point(input logic [ELEM_W-1:0] px, py, pz);
		logic signed [127:0] acc;
		logic [ELEM_W-1:0]   coord [NCOMP];
		point_beat_t         beat;
		coord[0] = px;
		coord[1] = py;
		coord[2] = pz;
		beat = '0;
		for (int i = 0; i < NCOMP; i++) begin
			acc = '0;
			for (int k = 0; k < NCOMP; k++)
				acc = acc + $signed(matrix_copy[k][i]) * $signed(coord[k]);
			acc = (acc >>> FRAC) + $signed(matrix_copy[NROW-1][i]);
			if (acc > SAT_MAX) begin
				acc = SAT_MAX;
				beat.sat = 1'b1;
			end else if (acc < SAT_MIN) begin
				acc = SAT_MIN;
				beat.sat = 1'b1;
			end
			case (i)
				0: beat.x = acc[ELEM_W-1:0];
				1: beat.y = acc[ELEM_W-1:0];
				default: beat.z = acc[ELEM_W-1:0];
			endcase
		end
		return beat;
	endfunction

	function automatic void apply_beat(input stim_t s);
		if (s.op == OP_WRITE)
			matrix_copy[s.row][s.col] = s.elem;
		else if (s.typed)
			pending_points.push_back(s.want);
		else
			pending_points.push_back(transform_point(s.px, s.py, s.pz));
	endfunction

	function automatic stim_t mk_write(input int row, input int col, input logic [ELEM_W-1:0] val);
		stim_t s;
		s.op    = OP_WRITE;
		s.row   = row[SEL_W-1:0];
		s.col   = col[SEL_W-1:0];
		s.elem  = val;
		s.px    = $urandom;
		s.py    = $urandom;
		s.pz    = $urandom;
		s.typed = 1'b0;
		s.want  = '0;
		return s;
	endfunction

	function automatic stim_t mk_point(input logic [ELEM_W-1:0] x, y, z);
		stim_t s;
		s.op    = OP_POINT;
		s.row   = SEL_W'($urandom_range(NROW - 1));
		s.col   = SEL_W'($urandom_range(NCOL - 1));
		s.elem  = $urandom;
		s.px    = x;
		s.py    = y;
		s.pz    = z;
		s.typed = 1'b0;
		s.want  = '0;
		return s;
	endfunction

	function automatic stim_t mk_checked(input logic [ELEM_W-1:0] x, y, z, ex, ey, ez,
			input logic sat);
		stim_t s;
		s       = mk_point(x, y, z);
		s.typed = 1'b1;
		s.want  = {ex, ey, ez, sat};
		return s;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		int pick;
		pick = $urandom_range(19);
		if (pick < 12)
			return $urandom_range(524288) - 262144;
		else if (pick < 16)
			return $urandom;
		else if (pick == 16)
			return '0;
		else if (pick == 17)
			return ONE;
		else if (pick == 18)
			return EMAX;
		return EMIN;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_coord();
		int pick;
		pick = $urandom_range(19);
		if (pick < 14)
			return $urandom_range(8388608) - 4194304;
		else if (pick < 18)
			return $urandom;
		else if (pick == 18)
			return EMAX;
		return EMIN;
	endfunction

	function automatic stim_t rand_item();
		if ($urandom_range(3) == 0)
			return mk_write($urandom_range(NROW - 1), $urandom_range(NCOL - 1), rand_elem());
		return mk_point(rand_coord(), rand_coord(), rand_coord());
	endfunction

	// Entered and left at a falling edge; valid stays high on return so that
	// back-to-back beats need no second assignment in one step.
	task automatic drive_item(input stim_t s);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.opcode     <= s.op;
		item_bus.row_sel    <= s.row;
		item_bus.col_sel    <= s.col;
		item_bus.elem_value <= s.elem;
		item_bus.point_x    <= s.px;
		item_bus.point_y    <= s.py;
		item_bus.point_z    <= s.pz;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		apply_beat(s);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		result_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_points.size() == 0) begin
				flag_error("result beat with no point pending");
			end else begin
				front_point = pending_points.pop_front();
				if (result_bus.out_x !== front_point.x)
					flag_error($sformatf("out_x %h, predicted %h", result_bus.out_x, front_point.x));
				if (result_bus.out_y !== front_point.y)
					flag_error($sformatf("out_y %h, predicted %h", result_bus.out_y, front_point.y));
				if (result_bus.out_z !== front_point.z)
					flag_error($sformatf("out_z %h, predicted %h", result_bus.out_z, front_point.z));
				if (result_bus.sat_flag !== front_point.sat)
					flag_error($sformatf("sat_flag %b, predicted %b", result_bus.sat_flag,
						front_point.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		item_bus.valid      = 1'b0;
		item_bus.opcode     = OP_WRITE;
		item_bus.row_sel    = '0;
		item_bus.col_sel    = '0;
		item_bus.elem_value = '0;
		item_bus.point_x    = '0;
		item_bus.point_y    = '0;
		item_bus.point_z    = '0;
		reset_matrix();

		// Identity after reset, the saturating translation in both directions,
		// a write to the unused column, floor rounding, and full-scale products.
		dir_rows.push_back(mk_checked(ONE, 32'h0002_0000, 32'hFFFD_0000,
			ONE, 32'h0002_0000, 32'hFFFD_0000, 1'b0));
		dir_rows.push_back(mk_checked(EMAX, EMIN, '0, EMAX, EMIN, '0, 1'b0));
		dir_rows.push_back(mk_checked(EMIN, EMAX, 32'hFFFF_FFFF,
			EMIN, EMAX, 32'hFFFF_FFFF, 1'b0));
		dir_rows.push_back(mk_write(3, 0, EMAX));
		dir_rows.push_back(mk_checked(ONE, '0, '0, EMAX, '0, '0, 1'b1));
		dir_rows.push_back(mk_write(3, 0, EMIN));
		dir_rows.push_back(mk_checked(NEG_ONE, '0, '0, EMIN, '0, '0, 1'b1));
		dir_rows.push_back(mk_write(3, 0, '0));
		dir_rows.push_back(mk_write(0, 3, 32'h1234_5678));
		dir_rows.push_back(mk_write(3, 3, EMIN));
		dir_rows.push_back(mk_checked(ONE, NEG_ONE, 32'h0002_0000,
			ONE, NEG_ONE, 32'h0002_0000, 1'b0));
		dir_rows.push_back(mk_write(0, 0, 32'h0000_8000));
		dir_rows.push_back(mk_checked(32'd1, '0, '0, '0, '0, '0, 1'b0));
		dir_rows.push_back(mk_checked(32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, '0, '0, 1'b0));
		dir_rows.push_back(mk_write(0, 0, EMAX));
		dir_rows.push_back(mk_write(1, 0, EMAX));
		dir_rows.push_back(mk_write(2, 0, EMAX));
		dir_rows.push_back(mk_point(EMAX, EMAX, EMAX));
		dir_rows.push_back(mk_point(EMIN, EMIN, EMIN));
		dir_rows.push_back(mk_write(2, 2, EMIN));
		dir_rows.push_back(mk_point('0, '0, EMIN));
		dir_rows.push_back(mk_write(1, 1, NEG_ONE));
		dir_rows.push_back(mk_point(32'd3, 32'hFFFF_FFFB, 32'd7));
		dir_rows.push_back(mk_write(3, 1, ONE));
		dir_rows.push_back(mk_point(ONE, 32'h0002_0000, 32'h0003_0000));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[n])
			drive_item(dir_rows[n]);

		for (int ph = 0; ph < NPHASE; ph++) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
			while (pending_points.size() != 0)
				@(negedge clk);
			case (ph)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 52;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 52;
				end
				default: begin
					gap_pct   = 21;
					stall_pct = 21;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				drive_item(rand_item());
		end

		item_bus.valid <= 1'b0;
		@(negedge clk);
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
